### sv/emcu_pkg.sv
`timescale 1ns / 1ps
package emcu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int CFG_BITS  = WORD_BITS - 1;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS = WORD_BITS;
  localparam int ADDR_BITS = 5;

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(64'sd1 <<< FRAC_BITS);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [CFG_BITS-1:0] cfgw_t;

  typedef enum logic [2:0] {
    REG_ALPHA = 3'd0,
    REG_DT    = 3'd1,
    REG_KK    = 3'd2,
    REG_A     = 3'd3,
    REG_B     = 3'd4,
    REG_EPS   = 3'd5,
    REG_M1    = 3'd6,
    REG_M2    = 3'd7
  } reg_idx_e;

  localparam cfgw_t RST_ALPHA = CFG_BITS'(0);
  localparam cfgw_t RST_DT    = CFG_BITS'(0);
  localparam cfgw_t RST_KK    = CFG_BITS'(134217728);
  localparam cfgw_t RST_A     = CFG_BITS'(1677722);
  localparam cfgw_t RST_B     = CFG_BITS'(1677722);
  localparam cfgw_t RST_EPS   = CFG_BITS'(167772);
  localparam cfgw_t RST_M1    = CFG_BITS'(1174405);
  localparam cfgw_t RST_M2    = CFG_BITS'(5033165);

  typedef struct packed {
    cfgw_t diffusion_gain;
    cfgw_t time_step;
    cfgw_t reaction_gain;
    cfgw_t threshold_a;
    cfgw_t recovery_offset_b;
    cfgw_t recovery_base_rate;
    cfgw_t recovery_gain_m1;
    cfgw_t recovery_denominator_m2;
  } cfg_t;

  typedef struct packed {
    word_t excitation_center;
    word_t excitation_north;
    word_t excitation_south;
    word_t excitation_west;
    word_t excitation_east;
    word_t recovery_now;
  } in_t;

  typedef struct packed {
    word_t excitation_next;
    word_t recovery_next;
    logic  range_fault;
  } out_t;

  // Payload that rides alongside the divider.
  typedef struct packed {
    word_t ex;
    word_t h;
    word_t r;
    logic  f;
  } side_t;

  typedef struct packed {
    logic  f;
    word_t v;
  } fx_t;

  function automatic word_t cfg_word(input cfgw_t x);
    return $signed({1'b0, x});
  endfunction

  function automatic fx_t fx_clip(input logic signed [63:0] x);
    fx_t res;
    res.f = 1'b0;
    if (x > SMAX) begin
      res.f = 1'b1;
      res.v = WORD_BITS'(SMAX);
    end else if (x < SMIN) begin
      res.f = 1'b1;
      res.v = WORD_BITS'(SMIN);
    end else begin
      res.v = WORD_BITS'(x);
    end
    return res;
  endfunction

  function automatic fx_t fx_add(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return fx_clip(s);
  endfunction

  function automatic fx_t fx_sub(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return fx_clip(s);
  endfunction

  // Floor of the product, scaled back by the fraction bits.
  function automatic fx_t fx_mul(input word_t a, input word_t b);
    logic signed [2*WORD_BITS-1:0] p;
    logic signed [63:0] s;
    p = a * b;
    s = 64'(p >>> FRAC_BITS);
    return fx_clip(s);
  endfunction

endpackage

### sv/emcu_cfg.sv
`timescale 1ns / 1ps
module emcu_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [emcu_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output emcu_pkg::cfg_t                   cfg_o
);

  emcu_pkg::cfg_t   cfg_q, cfg_d;
  emcu_pkg::cfgw_t  wval;
  emcu_pkg::cfgw_t  rval;
  emcu_pkg::reg_idx_e idx;

  assign idx    = emcu_pkg::reg_idx_e'(paddr[emcu_pkg::ADDR_BITS-1:2]);
  assign wval   = pwdata[emcu_pkg::CFG_BITS-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        emcu_pkg::REG_ALPHA: cfg_d.diffusion_gain          = wval;
        emcu_pkg::REG_DT:    cfg_d.time_step               = wval;
        emcu_pkg::REG_KK:    cfg_d.reaction_gain           = wval;
        emcu_pkg::REG_A:     cfg_d.threshold_a             = wval;
        emcu_pkg::REG_B:     cfg_d.recovery_offset_b       = wval;
        emcu_pkg::REG_EPS:   cfg_d.recovery_base_rate      = wval;
        emcu_pkg::REG_M1:    cfg_d.recovery_gain_m1        = wval;
        emcu_pkg::REG_M2:    cfg_d.recovery_denominator_m2 = wval;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      emcu_pkg::REG_ALPHA: rval = cfg_q.diffusion_gain;
      emcu_pkg::REG_DT:    rval = cfg_q.time_step;
      emcu_pkg::REG_KK:    rval = cfg_q.reaction_gain;
      emcu_pkg::REG_A:     rval = cfg_q.threshold_a;
      emcu_pkg::REG_B:     rval = cfg_q.recovery_offset_b;
      emcu_pkg::REG_EPS:   rval = cfg_q.recovery_base_rate;
      emcu_pkg::REG_M1:    rval = cfg_q.recovery_gain_m1;
      emcu_pkg::REG_M2:    rval = cfg_q.recovery_denominator_m2;
      default:             rval = '0;
    endcase
    prdata = {1'b0, rval};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diffusion_gain          <= emcu_pkg::RST_ALPHA;
      cfg_q.time_step               <= emcu_pkg::RST_DT;
      cfg_q.reaction_gain           <= emcu_pkg::RST_KK;
      cfg_q.threshold_a             <= emcu_pkg::RST_A;
      cfg_q.recovery_offset_b       <= emcu_pkg::RST_B;
      cfg_q.recovery_base_rate      <= emcu_pkg::RST_EPS;
      cfg_q.recovery_gain_m1        <= emcu_pkg::RST_M1;
      cfg_q.recovery_denominator_m2 <= emcu_pkg::RST_M2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/emcu_div.sv
`timescale 1ns / 1ps
module emcu_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  emcu_pkg::word_t       num_i,
  input  emcu_pkg::word_t       den_i,
  input  emcu_pkg::side_t       side_i,
  output logic                  valid_o,
  output emcu_pkg::word_t       quo_o,
  output logic                  fault_o,
  output emcu_pkg::side_t       side_o
);

  localparam int W = emcu_pkg::WORD_BITS;

  typedef struct packed {
    logic [W-1:0]    rem;
    logic [W-1:0]    lq;
    logic [W-1:0]    den;
    logic            neg;
    logic            ovf;
    logic            dbad;
    emcu_pkg::side_t side;
  } dstg_t;

  dstg_t d_q [0:emcu_pkg::DIV_STEPS];
  dstg_t d_d [0:emcu_pkg::DIV_STEPS];
  logic  v_q [0:emcu_pkg::DIV_STEPS];

  logic [W-1:0]                    un;
  logic [emcu_pkg::NUM_BITS-1:0]   num;
  logic [emcu_pkg::NUM_BITS-W-1:0] top;

  // Prepare magnitude, overflow check and partial remainder.
  always_comb begin
    un  = num_i[W-1] ? W'(-num_i) : W'(num_i);
    num = {un, {emcu_pkg::FRAC_BITS{1'b0}}};
    top = num[emcu_pkg::NUM_BITS-1:W];
    d_d[0].den  = den_i;
    d_d[0].neg  = num_i[W-1];
    d_d[0].dbad = (den_i <= 0);
    d_d[0].ovf  = W'(top) >= den_i;
    d_d[0].rem  = W'(top);
    d_d[0].lq   = num[W-1:0];
    d_d[0].side = side_i;
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= emcu_pkg::DIV_STEPS; k++) begin : g_step
    logic [W:0] trial;
    always_comb begin
      d_d[k] = d_q[k-1];
      trial  = {d_q[k-1].rem, d_q[k-1].lq[W-1]};
      if (trial >= {1'b0, d_q[k-1].den}) begin
        d_d[k].rem = W'(trial - {1'b0, d_q[k-1].den});
        d_d[k].lq  = {d_q[k-1].lq[W-2:0], 1'b1};
      end else begin
        d_d[k].rem = W'(trial);
        d_d[k].lq  = {d_q[k-1].lq[W-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k <= emcu_pkg::DIV_STEPS; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        d_q[k] <= d_d[k];
      end
    end
  end

  dstg_t        last;
  logic [W-1:0] q;
  logic [W-1:0] half;

  assign last    = d_q[emcu_pkg::DIV_STEPS];
  assign q       = last.lq;
  assign half    = {1'b1, {(W-1){1'b0}}};
  assign valid_o = v_q[emcu_pkg::DIV_STEPS];
  assign side_o  = last.side;

  // Sign and saturate the quotient; a non-positive divisor gives zero and a fault.
  always_comb begin
    fault_o = 1'b0;
    quo_o   = '0;
    if (last.dbad) begin
      fault_o = 1'b1;
    end else if (last.ovf) begin
      fault_o = 1'b1;
      quo_o   = last.neg ? W'(emcu_pkg::SMIN) : W'(emcu_pkg::SMAX);
    end else if (!last.neg) begin
      if (q[W-1]) begin
        fault_o = 1'b1;
        quo_o   = W'(emcu_pkg::SMAX);
      end else begin
        quo_o = q;
      end
    end else begin
      if (q > half) begin
        fault_o = 1'b1;
        quo_o   = W'(emcu_pkg::SMIN);
      end else begin
        quo_o = W'(-q);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(valid_o))
    else $error("divider output valid moved during stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (v_q[0] == $past(valid_i)))
    else $error("divider entry valid lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last.dbad) |-> (fault_o && quo_o == '0))
    else $error("non-positive divisor not flagged");

endmodule

### sv/excitable_media_cell_update_top.sv
`timescale 1ns / 1ps
// One Aliev-Panfilov update per cell beat: the beat carries the cell's
// excitation, its four neighbors and its recovery value, and the result beat
// returns the next excitation, the next recovery value and a fault flag that
// is set when any intermediate step saturated or the divisor e+M2 was not
// positive. All values are signed Q8.24. The block takes one beat per clock
// unless the pipeline holds, and returns results in order through 8 stages
// of diffusion and reaction arithmetic (one multiply or add level each),
// 33 stages of the restoring divider (a setup stage, then one quotient bit per
// stage over 32 stages; the sign and saturation of the quotient are combined
// into the first recovery stage) and 4 stages that form the recovery update.
// The whole pipeline advances together; it holds only while a finished result
// sits at the output and out_stall_i is high.
// Configuration registers sit on the APB port at byte address 4*index and
// must be written only while the pipeline is empty.
module excitable_media_cell_update_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  emcu_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output emcu_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [emcu_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int FRONT = 8;
  localparam int BACK  = 4;

  typedef emcu_pkg::word_t word_t;

  // Working set of the front stages; each stage rewrites what it owns.
  typedef struct packed {
    word_t e;
    word_t en;
    word_t es;
    word_t r;
    word_t lap;
    word_t e4;
    word_t t1;
    word_t t;
    word_t s_ea;
    word_t s_e1;
    word_t s_eb;
    word_t mr;
    word_t dv;
    word_t pe;
    word_t nr;
    word_t h;
    word_t tdt;
    word_t ex;
    logic  f;
  } st_t;

  typedef struct packed {
    word_t ex;
    word_t h;
    word_t r;
    word_t g;
    logic  f;
  } bk_t;

  emcu_pkg::cfg_t cfg;
  word_t alpha, dt, kk, ta, tb, eps, m1, m2;

  emcu_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign alpha = emcu_pkg::cfg_word(cfg.diffusion_gain);
  assign dt    = emcu_pkg::cfg_word(cfg.time_step);
  assign kk    = emcu_pkg::cfg_word(cfg.reaction_gain);
  assign ta    = emcu_pkg::cfg_word(cfg.threshold_a);
  assign tb    = emcu_pkg::cfg_word(cfg.recovery_offset_b);
  assign eps   = emcu_pkg::cfg_word(cfg.recovery_base_rate);
  assign m1    = emcu_pkg::cfg_word(cfg.recovery_gain_m1);
  assign m2    = emcu_pkg::cfg_word(cfg.recovery_denominator_m2);

  // The whole pipe moves unless a result waits at a stalled output.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  st_t              s_q [1:FRONT];
  st_t              s_d [1:FRONT];
  logic [FRONT-1:0] fv_q;

  // Stage 1: first adds and products straight off the input beat.
  always_comb begin
    emcu_pkg::fx_t x;
    s_d[1]    = '0;
    s_d[1].e  = in_data_i.excitation_center;
    s_d[1].en = in_data_i.excitation_north;
    s_d[1].es = in_data_i.excitation_south;
    s_d[1].r  = in_data_i.recovery_now;
    x = emcu_pkg::fx_add(s_d[1].e, s_d[1].e);
    s_d[1].e4 = x.v; s_d[1].f = x.f;
    x = emcu_pkg::fx_add(in_data_i.excitation_east, in_data_i.excitation_west);
    s_d[1].lap = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_mul(kk, s_d[1].e);
    s_d[1].t1 = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_sub(s_d[1].e, ta);
    s_d[1].s_ea = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_sub(s_d[1].e, emcu_pkg::ONE);
    s_d[1].s_e1 = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_sub(s_d[1].e, tb);
    s_d[1].s_eb = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_mul(m1, s_d[1].r);
    s_d[1].mr = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_add(s_d[1].e, m2);
    s_d[1].dv = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_mul(s_d[1].e, s_d[1].r);
    s_d[1].pe = x.v; s_d[1].f |= x.f;
    x = emcu_pkg::fx_sub('0, s_d[1].r);
    s_d[1].nr = x.v; s_d[1].f |= x.f;
  end

  // Stages 2 to 8: the Laplacian, the cubic term, h and the new excitation.
  always_comb begin
    emcu_pkg::fx_t x;
    s_d[2] = s_q[1];
    x = emcu_pkg::fx_add(s_q[1].e4, s_q[1].e4);
    s_d[2].e4 = x.v; s_d[2].f |= x.f;
    x = emcu_pkg::fx_mul(s_q[1].t1, s_q[1].s_ea);
    s_d[2].t = x.v; s_d[2].f |= x.f;
    x = emcu_pkg::fx_sub(s_q[1].s_eb, emcu_pkg::ONE);
    s_d[2].s_eb = x.v; s_d[2].f |= x.f;

    s_d[3] = s_q[2];
    x = emcu_pkg::fx_sub(s_q[2].lap, s_q[2].e4);
    s_d[3].lap = x.v; s_d[3].f |= x.f;
    x = emcu_pkg::fx_mul(s_q[2].t, s_q[2].s_e1);
    s_d[3].t = x.v; s_d[3].f |= x.f;
    x = emcu_pkg::fx_mul(s_q[2].t1, s_q[2].s_eb);
    s_d[3].h = x.v; s_d[3].f |= x.f;

    s_d[4] = s_q[3];
    x = emcu_pkg::fx_add(s_q[3].lap, s_q[3].es);
    s_d[4].lap = x.v; s_d[4].f |= x.f;
    x = emcu_pkg::fx_add(s_q[3].t, s_q[3].pe);
    s_d[4].t = x.v; s_d[4].f |= x.f;
    x = emcu_pkg::fx_sub(s_q[3].nr, s_q[3].h);
    s_d[4].h = x.v; s_d[4].f |= x.f;

    s_d[5] = s_q[4];
    x = emcu_pkg::fx_add(s_q[4].lap, s_q[4].en);
    s_d[5].lap = x.v; s_d[5].f |= x.f;
    x = emcu_pkg::fx_mul(dt, s_q[4].t);
    s_d[5].tdt = x.v; s_d[5].f |= x.f;

    s_d[6] = s_q[5];
    x = emcu_pkg::fx_mul(alpha, s_q[5].lap);
    s_d[6].lap = x.v; s_d[6].f |= x.f;

    s_d[7] = s_q[6];
    x = emcu_pkg::fx_add(s_q[6].e, s_q[6].lap);
    s_d[7].ex = x.v; s_d[7].f |= x.f;

    s_d[8] = s_q[7];
    x = emcu_pkg::fx_sub(s_q[7].ex, s_q[7].tdt);
    s_d[8].ex = x.v; s_d[8].f |= x.f;
  end

  for (genvar k = 1; k <= FRONT; k++) begin : g_front
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[k] <= s_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[FRONT-2:0], in_valid_i};
    end
  end

  // Divide M1*r by e+M2 while the rest of the beat rides along.
  emcu_pkg::side_t side_in, side_out;
  logic            dv_valid, dv_fault;
  word_t           quo;

  assign side_in.ex = s_q[FRONT].ex;
  assign side_in.h  = s_q[FRONT].h;
  assign side_in.r  = s_q[FRONT].r;
  assign side_in.f  = s_q[FRONT].f;

  emcu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(fv_q[FRONT-1]),
    .num_i  (s_q[FRONT].mr),
    .den_i  (s_q[FRONT].dv),
    .side_i (side_in),
    .valid_o(dv_valid),
    .quo_o  (quo),
    .fault_o(dv_fault),
    .side_o (side_out)
  );

  // Back stages: g = eps + quotient, then dt*g, then times h, then add r.
  bk_t             b_q [1:BACK-1];
  bk_t             b_d [1:BACK-1];
  logic [BACK-1:0] bv_q;
  emcu_pkg::out_t  out_q, out_d;

  always_comb begin
    emcu_pkg::fx_t x;
    b_d[1].ex = side_out.ex;
    b_d[1].h  = side_out.h;
    b_d[1].r  = side_out.r;
    x = emcu_pkg::fx_add(eps, quo);
    b_d[1].g = x.v;
    b_d[1].f = side_out.f | dv_fault | x.f;

    b_d[2] = b_q[1];
    x = emcu_pkg::fx_mul(dt, b_q[1].g);
    b_d[2].g = x.v; b_d[2].f |= x.f;

    b_d[3] = b_q[2];
    x = emcu_pkg::fx_mul(b_q[2].g, b_q[2].h);
    b_d[3].g = x.v; b_d[3].f |= x.f;

    x = emcu_pkg::fx_add(b_q[3].r, b_q[3].g);
    out_d.excitation_next = b_q[3].ex;
    out_d.recovery_next   = x.v;
    out_d.range_fault     = b_q[3].f | x.f;
  end

  for (genvar k = 1; k < BACK; k++) begin : g_back
    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_q[k] <= b_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[BACK-2:0], dv_valid};
    end
  end

  assign out_valid_o = bv_q[BACK-1];
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(fv_q) && $stable(bv_q)))
    else $error("valid bits moved while the pipe was held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (fv_q[FRONT-1:1] == $past(fv_q[FRONT-2:0])))
    else $error("front valid bits did not shift together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (bv_q[0] == $past(dv_valid)))
    else $error("beat lost between divider and back stages");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("held result changed");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;  // a little more than the pipeline depth
  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  emcu_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  emcu_pkg::out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [emcu_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  excitable_media_cell_update_top i_dut (.*);

  // Shadow copy of the parameter registers, indexed by reg_idx_e.
  logic signed [63:0] coef [8];
  emcu_pkg::in_t cell_q [$];
  emcu_pkg::out_t update_q [$];
  int mismatches = 0;
  int cycles = 0;
  bit steady = 1'b0;   // suppress idling on both sides
  bit hold_send = 1'b0;
  bit step_fault;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic signed [63:0] clamp(input logic signed [63:0] x);
    if (x > WMAX) begin
      step_fault = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      step_fault = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a, b);
    return clamp(a + b);
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a, b);
    return clamp(a - b);
  endfunction

  // Floor of the scaled product.
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a, b);
    logic signed [63:0] p;
    p = a * b;
    return clamp(p >>> 24);
  endfunction

  // Quotient truncated toward zero; a non-positive divisor gives zero.
  function automatic logic signed [63:0] q_div(input logic signed [63:0] n, d);
    logic signed [63:0] m, q;
    if (d <= 0) begin
      step_fault = 1'b1;
      return 64'sd0;
    end
    m = (n < 0) ? -n : n;
    q = (m <<< 24) / d;
    return clamp((n < 0) ? -q : q);
  endfunction

  function automatic emcu_pkg::out_t cell_update(input emcu_pkg::in_t c);
    logic signed [63:0] e, r, e4, lap, en, t, g, h, rn;
    emcu_pkg::out_t o;
    step_fault = 1'b0;
    e = 64'(c.excitation_center);
    r = 64'(c.recovery_now);
    e4 = q_add(e, e);
    e4 = q_add(e4, e4);
    lap = q_add(64'(c.excitation_east), 64'(c.excitation_west));
    lap = q_sub(lap, e4);
    lap = q_add(lap, 64'(c.excitation_south));
    lap = q_add(lap, 64'(c.excitation_north));
    en = q_add(e, q_mul(coef[emcu_pkg::REG_ALPHA], lap));
    t = q_mul(coef[emcu_pkg::REG_KK], e);
    t = q_mul(t, q_sub(e, coef[emcu_pkg::REG_A]));
    t = q_mul(t, q_sub(e, Q_ONE));
    t = q_add(t, q_mul(e, r));
    en = q_sub(en, q_mul(coef[emcu_pkg::REG_DT], t));
    g = q_add(coef[emcu_pkg::REG_EPS], q_div(q_mul(coef[emcu_pkg::REG_M1], r),
                                             q_add(e, coef[emcu_pkg::REG_M2])));
    h = q_mul(q_mul(coef[emcu_pkg::REG_KK], e),
              q_sub(q_sub(e, coef[emcu_pkg::REG_B]), Q_ONE));
    h = q_sub(q_sub(64'sd0, r), h);
    rn = q_add(r, q_mul(q_mul(coef[emcu_pkg::REG_DT], g), h));
    o.excitation_next = emcu_pkg::word_t'(en);
    o.recovery_next = emcu_pkg::word_t'(rn);
    o.range_fault = step_fault;
    return o;
  endfunction

  task automatic report(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Driver: advance to the next cell when the current beat is taken or none is up.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) update_q.push_back(cell_update(in_data_i));
    if (!in_valid_i || !in_stall_o) begin
      if (cell_q.size() > 0 && !hold_send && (steady || $urandom_range(99) >= 26)) begin
        in_valid_i <= 1'b1;
        in_data_i <= cell_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    emcu_pkg::out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (update_q.size() == 0) begin
        report("result beat with no prediction pending");
      end else begin
        want = update_q.pop_front();
        if (out_data_o.excitation_next !== want.excitation_next)
          report($sformatf("excitation_next %h, want %h",
                           out_data_o.excitation_next, want.excitation_next));
        if (out_data_o.recovery_next !== want.recovery_next)
          report($sformatf("recovery_next %h, want %h",
                           out_data_o.recovery_next, want.recovery_next));
        if (out_data_o.range_fault !== want.range_fault)
          report($sformatf("range_fault %b, want %b",
                           out_data_o.range_fault, want.range_fault));
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 26);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Two-phase APB write; the shadow copy drops bit 31 like the register does.
  task automatic write_reg(input emcu_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= emcu_pkg::ADDR_BITS'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    coef[idx] = 64'(val & 32'h7fff_ffff);
  endtask

  task automatic drain();
    while (cell_q.size() > 0 || in_valid_i || update_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly cells near the physical range, some with arbitrary bit patterns.
  function automatic emcu_pkg::word_t pick_value();
    if ($urandom_range(99) < 70)
      return emcu_pkg::word_t'($signed($urandom_range(67108864)) - 33554432);
    return emcu_pkg::word_t'($urandom);
  endfunction

  task automatic queue_random_cells(input int n);
    emcu_pkg::in_t c;
    repeat (n) begin
      c.excitation_center = pick_value();
      c.excitation_north = pick_value();
      c.excitation_south = pick_value();
      c.excitation_west = pick_value();
      c.excitation_east = pick_value();
      c.recovery_now = pick_value();
      if ($urandom_range(19) == 0)
        c.excitation_center =
          emcu_pkg::word_t'(-coef[emcu_pkg::REG_M2] - $urandom_range(1));
      cell_q.push_back(c);
    end
  endtask

  task automatic queue_cell(input emcu_pkg::word_t e, n, s, w, x, r);
    cell_q.push_back('{e, n, s, w, x, r});
  endtask

  task automatic set_params(input logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(emcu_pkg::REG_ALPHA, v0);
    write_reg(emcu_pkg::REG_DT, v1);
    write_reg(emcu_pkg::REG_KK, v2);
    write_reg(emcu_pkg::REG_A, v3);
    write_reg(emcu_pkg::REG_B, v4);
    write_reg(emcu_pkg::REG_EPS, v5);
    write_reg(emcu_pkg::REG_M1, v6);
    write_reg(emcu_pkg::REG_M2, v7);
  endtask

  initial begin
    coef[emcu_pkg::REG_ALPHA] = 64'(emcu_pkg::RST_ALPHA);
    coef[emcu_pkg::REG_DT] = 64'(emcu_pkg::RST_DT);
    coef[emcu_pkg::REG_KK] = 64'(emcu_pkg::RST_KK);
    coef[emcu_pkg::REG_A] = 64'(emcu_pkg::RST_A);
    coef[emcu_pkg::REG_B] = 64'(emcu_pkg::RST_B);
    coef[emcu_pkg::REG_EPS] = 64'(emcu_pkg::RST_EPS);
    coef[emcu_pkg::REG_M1] = 64'(emcu_pkg::RST_M1);
    coef[emcu_pkg::REG_M2] = 64'(emcu_pkg::RST_M2);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cells under reset parameters, then under typical ones.
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 1) set_params(32'h0010_0000, 32'h0004_0000, 32'(emcu_pkg::RST_KK),
                              32'(emcu_pkg::RST_A), 32'(emcu_pkg::RST_B),
                              32'(emcu_pkg::RST_EPS), 32'(emcu_pkg::RST_M1),
                              32'(emcu_pkg::RST_M2));
      queue_cell(0, 0, 0, 0, 0, 0);
      queue_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff);
      queue_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
      queue_cell(32'hffff_ffff, 0, 32'hffff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff);
      queue_cell(32'h0100_0000, 32'h0100_0000, 0, 0, 32'h0100_0000, 32'h0080_0000);
      // divisor e + M2 exactly zero, then negative
      queue_cell(emcu_pkg::word_t'(-coef[emcu_pkg::REG_M2]), 0, 0, 0, 0, 32'h0100_0000);
      queue_cell(32'hff00_0000, 0, 0, 0, 0, 32'hff00_0000);
      queue_cell(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000);
      queue_cell(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 1, 1);
      queue_cell(32'h0019_999a, 32'h0100_0000, 32'h0100_0000, 0, 0, 0);
      drain();
    end

    // Random phases across parameter settings, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_params(32'h0010_0000, 32'h0004_0000, 32'h0800_0000, 32'h0019_999a,
                      32'h0019_999a, 32'h0002_8f5c, 32'h0011_eb85, 32'h004c_cccd);
        1: set_params(0, 0, 0, 0, 0, 0, 0, 0);
        2: set_params(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        default: set_params($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom_range(1, 32'h0200_0000));
      endcase
      steady = (ph == 3);
      queue_random_cells(80);
      if (ph == 0) begin
        // Let the pipeline empty out before the sender continues.
        while (cell_q.size() > 40) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_valid_i || update_q.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      queue_random_cells(80);
      drain();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
sv/emcu_pkg.sv
sv/emcu_cfg.sv
sv/emcu_div.sv
sv/excitable_media_cell_update_top.sv
tb/testbench.sv
